@@ rtl/core/mrp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrp_pkg
// types, character codes and result codes shared by the modem response parser
// ----------------------------------------------------------------------------
`default_nettype none

package mrp_pkg;

  // largest payload the design supports, independent of the register
  localparam int unsigned PAYLOAD_LIMIT = 4096;
  localparam logic [12:0] LIMIT_CAP =
    (PAYLOAD_LIMIT > 8191) ? 13'd8191 : 13'(PAYLOAD_LIMIT);
  localparam logic [12:0] MAX_PAYLOAD_RESET = 13'd1024;

  // result codes
  localparam logic [2:0] KIND_BYTE    = 3'd0;
  localparam logic [2:0] KIND_FRAME   = 3'd1;
  localparam logic [2:0] KIND_MERR    = 3'd2;
  localparam logic [2:0] KIND_ACK     = 3'd3;
  localparam logic [2:0] KIND_TXDONE  = 3'd4;
  localparam logic [2:0] KIND_PERR    = 3'd5;
  localparam logic [2:0] KIND_ACCEPT  = 3'd6;
  localparam logic [2:0] KIND_REFUSE  = 3'd7;

  // ascii characters of the response grammar
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  // 'A' - 10, so that c - HEX_BIAS gives the nibble of A..F
  localparam logic [7:0] HEX_BIAS  = 8'h37;

  typedef struct packed {
    logic       digit;
    logic       alpha;
    logic       cmd;
    logic       hex;
    logic [3:0] nibble;
  } char_class_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  data;
    logic [12:0] payload_len;
    logic        tx_ready;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/mrp_if.sv @@
// ----------------------------------------------------------------------------
// mrp_feed_if / mrp_report_if
// valid/ready channels into and out of the modem response parser
// ----------------------------------------------------------------------------
`default_nettype none

interface mrp_feed_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface mrp_report_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [12:0] payload_len;
  logic        tx_ready;

  modport source (output valid, output kind, output data, output payload_len,
                  output tx_ready, input ready);
  modport sink   (input valid, input kind, input data, input payload_len,
                  input tx_ready, output ready);
endinterface

`default_nettype wire

@@ rtl/core/mrp_char_class.sv @@
// ----------------------------------------------------------------------------
// mrp_char_class
// classifies one received character for the grammar checks
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_char_class (
  input  wire logic [7:0]          c,
  output mrp_pkg::char_class_t     cls
);
  import mrp_pkg::*;

  logic digit;
  logic upper;
  logic lower;
  logic [7:0] hex_diff;

  assign digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign upper = (c >= CH_A) && (c <= CH_Z);
  assign lower = (c >= CH_LA) && (c <= CH_LZ);
  assign hex_diff = (c >= CH_A) ? (c - HEX_BIAS) : (c - CH_ZERO);

  always_comb begin
    cls.digit  = digit;
    cls.alpha  = upper || lower;
    cls.cmd    = (c == CH_H) || (c == CH_T) || (c == CH_X) || (c == CH_D) ||
                 (c == CH_A) || (c == CH_C) || (c == CH_W) || (c == CH_R);
    cls.hex    = digit || ((c >= CH_A) && (c <= CH_F));
    cls.nibble = hex_diff[3:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/mrp_parser.sv @@
// ----------------------------------------------------------------------------
// mrp_parser
// response grammar state machine, hex decoder and transmit handshake
// ----------------------------------------------------------------------------
`default_nettype none

module mrp_parser (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 mode,
  input  wire logic [7:0]           c,
  input  wire mrp_pkg::char_class_t cls,
  input  wire logic [12:0]          limit,
  output logic                      res_valid,
  output mrp_pkg::result_t          res
);
  import mrp_pkg::*;

  typedef enum logic [36:0] {
    PS_IDLE     = 37'd1 << 0,  PS_DOLLAR   = 37'd1 << 1,  PS_M        = 37'd1 << 2,
    PS_MM       = 37'd1 << 3,  PS_E        = 37'd1 << 4,  PS_ER       = 37'd1 << 5,
    PS_ERR      = 37'd1 << 6,  PS_ERR_C1   = 37'd1 << 7,  PS_ERR_CMD  = 37'd1 << 8,
    PS_ERR_C2   = 37'd1 << 9,  PS_ERR_CODE = 37'd1 << 10, PS_ERR_CR   = 37'd1 << 11,
    PS_O        = 37'd1 << 12, PS_OK       = 37'd1 << 13, PS_OKY      = 37'd1 << 14,
    PS_OKY_C1   = 37'd1 << 15, PS_OKY_CMD  = 37'd1 << 16, PS_OKY_ARGS = 37'd1 << 17,
    PS_OKY_CR   = 37'd1 << 18, PS_R        = 37'd1 << 19, PS_RX       = 37'd1 << 20,
    PS_RXD      = 37'd1 << 21, PS_RXD_C1   = 37'd1 << 22, PS_RXD_SRC  = 37'd1 << 23,
    PS_RXD_C2   = 37'd1 << 24, PS_RXD_DST  = 37'd1 << 25, PS_RXD_C3   = 37'd1 << 26,
    PS_RXD_DATA = 37'd1 << 27, PS_RXD_CR   = 37'd1 << 28, PS_T        = 37'd1 << 29,
    PS_TD       = 37'd1 << 30, PS_TDN      = 37'd1 << 31, PS_TDN_C1   = 37'd1 << 32,
    PS_TDN_RES  = 37'd1 << 33, PS_TDN_C2   = 37'd1 << 34, PS_TDN_PN   = 37'd1 << 35,
    PS_TDN_CR   = 37'd1 << 36
  } parse_state_t;

  typedef enum logic [2:0] {
    HS_READY    = 3'b001,
    HS_WAIT_OKY = 3'b010,
    HS_WAIT_TDN = 3'b100
  } hs_state_t;

  parse_state_t parse_state, parse_state_next;
  hs_state_t    hs_state, hs_state_next;
  logic [3:0]   high_nibble, high_nibble_next;
  logic         nibble_phase, nibble_phase_next;
  logic [12:0]  payload_count, payload_count_next;

  logic        bad;
  logic        emit;
  logic [2:0]  kind;
  logic [7:0]  data;
  logic [12:0] len;

  always_comb begin
    parse_state_next   = parse_state;
    hs_state_next      = hs_state;
    high_nibble_next   = high_nibble;
    nibble_phase_next  = nibble_phase;
    payload_count_next = payload_count;
    bad  = 1'b0;
    emit = 1'b0;
    kind = KIND_BYTE;
    data = 8'd0;
    len  = 13'd0;

    if (mode) begin
      // transmit request leaves the parser alone
      emit = 1'b1;
      if (hs_state == HS_READY) begin
        hs_state_next = HS_WAIT_OKY;
        kind          = KIND_ACCEPT;
      end else begin
        kind = KIND_REFUSE;
      end
    end else begin
      case (parse_state)
        PS_IDLE:   if (c == CH_DOLLAR) parse_state_next = PS_DOLLAR; else bad = 1'b1;
        PS_DOLLAR: if (c == CH_M) parse_state_next = PS_M; else bad = 1'b1;
        PS_M:      if (c == CH_M) parse_state_next = PS_MM; else bad = 1'b1;
        PS_MM: begin
          if (c == CH_E)      parse_state_next = PS_E;
          else if (c == CH_O) parse_state_next = PS_O;
          else if (c == CH_R) parse_state_next = PS_R;
          else if (c == CH_T) parse_state_next = PS_T;
          else                bad = 1'b1;
        end
        // error line
        PS_E:      if (c == CH_R) parse_state_next = PS_ER; else bad = 1'b1;
        PS_ER:     if (c == CH_R) parse_state_next = PS_ERR; else bad = 1'b1;
        PS_ERR:    if (c == CH_COMMA) parse_state_next = PS_ERR_C1; else bad = 1'b1;
        PS_ERR_C1: if (cls.cmd) parse_state_next = PS_ERR_CMD; else bad = 1'b1;
        PS_ERR_CMD: begin
          if (cls.cmd)             parse_state_next = PS_ERR_CMD;
          else if (c == CH_COMMA)  parse_state_next = PS_ERR_C2;
          else                     bad = 1'b1;
        end
        PS_ERR_C2: if (cls.digit) parse_state_next = PS_ERR_CODE; else bad = 1'b1;
        PS_ERR_CODE: begin
          if (cls.digit)        parse_state_next = PS_ERR_CODE;
          else if (c == CH_CR)  parse_state_next = PS_ERR_CR;
          else                  bad = 1'b1;
        end
        PS_ERR_CR: begin
          if (c == CH_LF) begin
            parse_state_next = PS_IDLE;
            emit = 1'b1;
            kind = KIND_MERR;
          end else begin
            bad = 1'b1;
          end
        end
        // ack line
        PS_O:      if (c == CH_K) parse_state_next = PS_OK; else bad = 1'b1;
        PS_OK:     if (c == CH_Y) parse_state_next = PS_OKY; else bad = 1'b1;
        PS_OKY:    if (c == CH_COMMA) parse_state_next = PS_OKY_C1; else bad = 1'b1;
        PS_OKY_C1: if (cls.cmd) parse_state_next = PS_OKY_CMD; else bad = 1'b1;
        PS_OKY_CMD: begin
          if (cls.cmd)            parse_state_next = PS_OKY_CMD;
          else if (c == CH_COMMA) parse_state_next = PS_OKY_ARGS;
          else if (c == CH_CR)    parse_state_next = PS_OKY_CR;
          else                    bad = 1'b1;
        end
        PS_OKY_ARGS: begin
          if (cls.digit || cls.alpha || (c == CH_COMMA)) parse_state_next = PS_OKY_ARGS;
          else if (c == CH_CR)                           parse_state_next = PS_OKY_CR;
          else                                           bad = 1'b1;
        end
        PS_OKY_CR: begin
          if (c == CH_LF) begin
            parse_state_next = PS_IDLE;
            hs_state_next    = HS_WAIT_TDN;
            emit = 1'b1;
            kind = KIND_ACK;
          end else begin
            bad = 1'b1;
          end
        end
        // received data line
        PS_R:      if (c == CH_X) parse_state_next = PS_RX; else bad = 1'b1;
        PS_RX:     if (c == CH_D) parse_state_next = PS_RXD; else bad = 1'b1;
        PS_RXD:    if (c == CH_COMMA) parse_state_next = PS_RXD_C1; else bad = 1'b1;
        PS_RXD_C1: if (cls.digit) parse_state_next = PS_RXD_SRC; else bad = 1'b1;
        PS_RXD_SRC: begin
          if (cls.digit)          parse_state_next = PS_RXD_SRC;
          else if (c == CH_COMMA) parse_state_next = PS_RXD_C2;
          else                    bad = 1'b1;
        end
        PS_RXD_C2: if (cls.digit) parse_state_next = PS_RXD_DST; else bad = 1'b1;
        PS_RXD_DST: begin
          if (cls.digit)          parse_state_next = PS_RXD_DST;
          else if (c == CH_COMMA) parse_state_next = PS_RXD_C3;
          else                    bad = 1'b1;
        end
        PS_RXD_C3: begin
          if (cls.hex) begin
            payload_count_next = 13'd0;
            high_nibble_next   = cls.nibble;
            nibble_phase_next  = 1'b1;
            parse_state_next   = PS_RXD_DATA;
          end else begin
            bad = 1'b1;
          end
        end
        PS_RXD_DATA: begin
          if (cls.hex) begin
            if (!nibble_phase) begin
              high_nibble_next  = cls.nibble;
              nibble_phase_next = 1'b1;
            end else begin
              nibble_phase_next = 1'b0;
              if (payload_count >= limit) begin
                bad = 1'b1;
              end else begin
                emit = 1'b1;
                kind = KIND_BYTE;
                data = {high_nibble, cls.nibble};
                payload_count_next = payload_count + 13'd1;
              end
            end
          end else if (c == CH_CR) begin
            parse_state_next = PS_RXD_CR;
          end else begin
            bad = 1'b1;
          end
        end
        PS_RXD_CR: begin
          if (c == CH_LF) begin
            parse_state_next = PS_IDLE;
            emit = 1'b1;
            kind = KIND_FRAME;
            len  = payload_count;
          end else begin
            bad = 1'b1;
          end
        end
        // transmit done line
        PS_T:      if (c == CH_D) parse_state_next = PS_TD; else bad = 1'b1;
        PS_TD:     if (c == CH_N) parse_state_next = PS_TDN; else bad = 1'b1;
        PS_TDN:    if (c == CH_COMMA) parse_state_next = PS_TDN_C1; else bad = 1'b1;
        PS_TDN_C1: if (cls.digit) parse_state_next = PS_TDN_RES; else bad = 1'b1;
        PS_TDN_RES: begin
          if (cls.digit)          parse_state_next = PS_TDN_RES;
          else if (c == CH_COMMA) parse_state_next = PS_TDN_C2;
          else                    bad = 1'b1;
        end
        PS_TDN_C2: if (cls.digit) parse_state_next = PS_TDN_PN; else bad = 1'b1;
        PS_TDN_PN: begin
          if (cls.digit)        parse_state_next = PS_TDN_PN;
          else if (c == CH_CR)  parse_state_next = PS_TDN_CR;
          else                  bad = 1'b1;
        end
        PS_TDN_CR: begin
          if (c == CH_LF) begin
            parse_state_next = PS_IDLE;
            hs_state_next    = HS_READY;
            emit = 1'b1;
            kind = KIND_TXDONE;
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase

      if (bad) begin
        parse_state_next  = PS_IDLE;
        nibble_phase_next = 1'b0;
        emit = 1'b1;
        kind = KIND_PERR;
        data = 8'd0;
        len  = 13'd0;
      end else if (parse_state_next == PS_IDLE) begin
        nibble_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= PS_IDLE;
      hs_state      <= HS_READY;
      high_nibble   <= 4'd0;
      nibble_phase  <= 1'b0;
      payload_count <= 13'd0;
    end else if (step) begin
      parse_state   <= parse_state_next;
      hs_state      <= hs_state_next;
      high_nibble   <= high_nibble_next;
      nibble_phase  <= nibble_phase_next;
      payload_count <= payload_count_next;
    end
  end

  assign res_valid       = emit;
  assign res.kind        = kind;
  assign res.data        = data;
  assign res.payload_len = len;
  assign res.tx_ready    = (hs_state_next == HS_READY);

endmodule

`default_nettype wire

@@ rtl/core/modem_response_parser.sv @@
// ----------------------------------------------------------------------------
// modem_response_parser
// byte-wise parser of the modem's serial responses with transmit handshake
// ----------------------------------------------------------------------------
// Takes one word per clock on feed: either a received ASCII character
// (mode 0) or a transmit request (mode 1). Characters are checked against the
// $MMERR / $MMOKY / $MMTDN / $MMRXD line grammar, each line closed by CR LF.
// Each hex pair of an RXD line gives a payload byte word on report, the LF of
// an RXD line gives a frame done word with the byte count, and ERR, OKY and
// TDN lines give modem error, ack and tx done words. A character the grammar
// does not allow, or a payload byte beyond the limit, gives a parse error
// word and drops back to idle. Throughput is one word per clock while report
// takes every result; a result word passes from the input register through
// the combinational next state logic of the parser into the result register.
// A result left waiting on report stalls feed once the input register holds
// the next word. Characters that only advance the grammar give no report
// word. The payload limit register (reset 1024) may only be written while
// no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module modem_response_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data,
  mrp_feed_if.sink         feed,
  mrp_report_if.source     report
);
  import mrp_pkg::*;

  // payload limit register and effective limit
  logic [12:0] max_payload_bytes;
  logic [12:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= MAX_PAYLOAD_RESET;
    end else if (cfg_wr_en) begin
      max_payload_bytes <= cfg_wr_data;
    end
  end

  assign limit = (max_payload_bytes > LIMIT_CAP) ? LIMIT_CAP : max_payload_bytes;

  // input register
  logic       in_valid;
  logic       in_mode;
  logic [7:0] in_byte;
  logic       advance;

  // result register
  logic    out_valid;
  result_t out_res;

  logic        res_valid;
  result_t     res;
  char_class_t cls;

  // the word in the input register moves on whenever the result register
  // is empty or being drained this cycle
  assign advance     = in_valid && (!out_valid || report.ready);
  assign feed.ready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (feed.ready) begin
      in_valid <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) begin
      in_mode <= feed.mode;
      in_byte <= feed.rx_byte;
    end
  end

  mrp_char_class u_char_class (
    .c   (in_byte),
    .cls (cls)
  );

  mrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .mode      (in_mode),
    .c         (in_byte),
    .cls       (cls),
    .limit     (limit),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register: filled by a word that gives a result, emptied on take
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign report.valid       = out_valid;
  assign report.kind        = out_res.kind;
  assign report.data        = out_res.data;
  assign report.payload_len = out_res.payload_len;
  assign report.tx_ready    = out_res.tx_ready;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the modem response parser
// ----------------------------------------------------------------------------
// Feeds serial characters and transmit requests into the parser and checks
// every report word against a behavioural model of the line grammar, the rx
// payload decoder and the transmit handshake kept in this module. A short
// directed table opens the run, then randomised phases of well-formed lines
// with random content, broken lines and noise follow. Each phase runs under
// its own payload limit. Both channels idle at random, apart from one phase
// with no idling at all.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import mrp_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_WORDS  = 112;
  localparam int IDLE_PERCENT = 27;
  localparam int STALL_LIMIT  = 2000;
  // two register stages between feed and report, plus some margin
  localparam int SETTLE_CYCLES = 4;

  // parser line states of the model; encoding is private to the bench
  typedef enum logic [5:0] {
    L_IDLE, L_DOLLAR, L_M, L_MM,
    L_E, L_ER, L_ERR, L_ERR_C1, L_ERR_CMD, L_ERR_C2, L_ERR_CODE, L_ERR_CR,
    L_O, L_OK, L_OKY, L_OKY_C1, L_OKY_CMD, L_OKY_ARGS, L_OKY_CR,
    L_R, L_RX, L_RXD, L_RXD_C1, L_RXD_SRC, L_RXD_C2, L_RXD_DST, L_RXD_C3,
    L_RXD_DATA, L_RXD_CR,
    L_T, L_TD, L_TDN, L_TDN_C1, L_TDN_RES, L_TDN_C2, L_TDN_PN, L_TDN_CR,
    L_BAD = 6'd63
  } line_state_e;

  typedef enum logic [1:0] {HS_READY, HS_WAIT_OKY, HS_WAIT_TDN} tx_state_e;

  // character classes used to build random lines
  typedef enum int {CLS_DIGIT, CLS_CMD, CLS_HEX, CLS_ARG} char_cls_e;

  // one row of the directed table: a run of characters (right-justified,
  // first character in the top byte) with an optional hand-typed report for
  // the last one
  typedef struct packed {
    logic        mode;
    logic [3:0]  n_chars;
    logic [95:0] text;
    logic        pinned;
    result_t     exp;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [12:0] cfg_wr_data;

  mrp_feed_if   feed ();
  mrp_report_if report ();

  modem_response_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .feed        (feed),
    .report      (report)
  );

  always #4 clk = ~clk;

  // -------------------------------------------------------------------------
  // model state
  // -------------------------------------------------------------------------
  line_state_e line_st    = L_IDLE;
  tx_state_e   tx_st      = HS_READY;
  logic [3:0]  hi_nib     = 4'd0;
  logic        nib_odd    = 1'b0;
  logic [12:0] byte_count = 13'd0;
  logic [12:0] limit_reg  = MAX_PAYLOAD_RESET;

  result_t     pending_reports [$];
  int          fails = 0;
  int          words_sent = 0;
  bit          steady = 1'b0;      // no idling on either side while set
  bit          typed_hit = 1'b0;   // word on feed carries a hand-typed report
  result_t     typed_word = '0;
  logic [7:0]  line_buf [$];

  // directed opening: handshake first, then extremes of the byte, then an
  // ack line and a tx done line that walk the handshake back to ready
  stim_row_t directed_words [6] = '{
    '{1'b1, 4'd1, 96'h00, 1'b1, '{KIND_ACCEPT, 8'd0, 13'd0, 1'b0}},
    '{1'b1, 4'd1, 96'hFF, 1'b1, '{KIND_REFUSE, 8'd0, 13'd0, 1'b0}},
    '{1'b0, 4'd1, 96'h00, 1'b1, '{KIND_PERR,   8'd0, 13'd0, 1'b0}},
    '{1'b0, 4'd1, 96'hFF, 1'b1, '{KIND_PERR,   8'd0, 13'd0, 1'b0}},
    '{1'b0, 4'd10, "$MMOKY,H\015\012", 1'b1, '{KIND_ACK, 8'd0, 13'd0, 1'b0}},
    '{1'b0, 4'd12, "$MMTDN,0,9\015\012", 1'b1, '{KIND_TXDONE, 8'd0, 13'd0, 1'b1}}
  };

  // -------------------------------------------------------------------------
  // character classes of the grammar
  // -------------------------------------------------------------------------
  function automatic bit is_dec(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic bit is_cmd_ch(logic [7:0] c);
    return c == CH_H || c == CH_T || c == CH_X || c == CH_D ||
           c == CH_A || c == CH_C || c == CH_W || c == CH_R;
  endfunction

  // upper-case hex only
  function automatic bit is_hex_ch(logic [7:0] c);
    return is_dec(c) || (c >= CH_A && c <= CH_F);
  endfunction

  function automatic logic [3:0] nib_of(logic [7:0] c);
    logic [7:0] v;
    v = (c >= CH_A) ? c - HEX_BIAS : c - CH_ZERO;
    return v[3:0];
  endfunction

  function automatic line_state_e need_char(logic [7:0] c, logic [7:0] ch,
                                            line_state_e nxt);
    return (c == ch) ? nxt : L_BAD;
  endfunction

  // stay on a run of allowed characters, leave on the separator
  function automatic line_state_e stay_or_sep(bit stay, logic [7:0] c,
                                              logic [7:0] sep,
                                              line_state_e cur,
                                              line_state_e nxt);
    if (stay) return cur;
    return (c == sep) ? nxt : L_BAD;
  endfunction

  // -------------------------------------------------------------------------
  // model of one feed word: updates the state, gives at most one report
  // -------------------------------------------------------------------------
  task automatic parse_word(input logic m, input logic [7:0] c,
                            output bit has, output result_t r);
    line_state_e ns;
    logic [2:0]  kind;
    logic [7:0]  dat;
    logic [12:0] len;
    logic [12:0] lim;
    bit          emit;
    ns   = L_BAD;
    kind = KIND_BYTE;
    dat  = 8'd0;
    len  = 13'd0;
    emit = 1'b0;
    has  = 1'b0;
    r    = '0;
    lim  = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;

    // transmit request: parse state is left alone
    if (m) begin
      if (tx_st == HS_READY) begin
        tx_st = HS_WAIT_OKY;
        kind  = KIND_ACCEPT;
      end else begin
        kind = KIND_REFUSE;
      end
      has = 1'b1;
      r   = '{kind, 8'd0, 13'd0, tx_st == HS_READY};
      return;
    end

    case (line_st)
      L_IDLE:     ns = need_char(c, CH_DOLLAR, L_DOLLAR);
      L_DOLLAR:   ns = need_char(c, CH_M, L_M);
      L_M:        ns = need_char(c, CH_M, L_MM);
      L_MM: begin
        ns = (c == CH_E) ? L_E : (c == CH_O) ? L_O :
             (c == CH_R) ? L_R : (c == CH_T) ? L_T : L_BAD;
      end
      // $MMERR,cmd,code
      L_E:        ns = need_char(c, CH_R, L_ER);
      L_ER:       ns = need_char(c, CH_R, L_ERR);
      L_ERR:      ns = need_char(c, CH_COMMA, L_ERR_C1);
      L_ERR_C1:   ns = is_cmd_ch(c) ? L_ERR_CMD : L_BAD;
      L_ERR_CMD:  ns = stay_or_sep(is_cmd_ch(c), c, CH_COMMA, L_ERR_CMD, L_ERR_C2);
      L_ERR_C2:   ns = is_dec(c) ? L_ERR_CODE : L_BAD;
      L_ERR_CODE: ns = stay_or_sep(is_dec(c), c, CH_CR, L_ERR_CODE, L_ERR_CR);
      L_ERR_CR: begin
        ns = need_char(c, CH_LF, L_IDLE);
        if (ns == L_IDLE) begin
          kind = KIND_MERR;
          emit = 1'b1;
        end
      end
      // $MMOKY,cmd[,args]
      L_O:        ns = need_char(c, CH_K, L_OK);
      L_OK:       ns = need_char(c, CH_Y, L_OKY);
      L_OKY:      ns = need_char(c, CH_COMMA, L_OKY_C1);
      L_OKY_C1:   ns = is_cmd_ch(c) ? L_OKY_CMD : L_BAD;
      L_OKY_CMD: begin
        ns = is_cmd_ch(c) ? L_OKY_CMD : (c == CH_COMMA) ? L_OKY_ARGS :
             (c == CH_CR) ? L_OKY_CR : L_BAD;
      end
      L_OKY_ARGS: begin
        ns = stay_or_sep(is_dec(c) || is_letter(c) || c == CH_COMMA, c, CH_CR,
                         L_OKY_ARGS, L_OKY_CR);
      end
      L_OKY_CR: begin
        ns = need_char(c, CH_LF, L_IDLE);
        // ack moves the handshake whatever state it is in
        if (ns == L_IDLE) begin
          kind  = KIND_ACK;
          emit  = 1'b1;
          tx_st = HS_WAIT_TDN;
        end
      end
      // $MMRXD,src,dst,hex
      L_R:        ns = need_char(c, CH_X, L_RX);
      L_RX:       ns = need_char(c, CH_D, L_RXD);
      L_RXD:      ns = need_char(c, CH_COMMA, L_RXD_C1);
      L_RXD_C1:   ns = is_dec(c) ? L_RXD_SRC : L_BAD;
      L_RXD_SRC:  ns = stay_or_sep(is_dec(c), c, CH_COMMA, L_RXD_SRC, L_RXD_C2);
      L_RXD_C2:   ns = is_dec(c) ? L_RXD_DST : L_BAD;
      L_RXD_DST:  ns = stay_or_sep(is_dec(c), c, CH_COMMA, L_RXD_DST, L_RXD_C3);
      L_RXD_C3: begin
        if (is_hex_ch(c)) begin
          byte_count = 13'd0;
          hi_nib     = nib_of(c);
          nib_odd    = 1'b1;
          ns         = L_RXD_DATA;
        end
      end
      L_RXD_DATA: begin
        if (is_hex_ch(c)) begin
          ns = L_RXD_DATA;
          if (!nib_odd) begin
            hi_nib  = nib_of(c);
            nib_odd = 1'b1;
          end else begin
            nib_odd = 1'b0;
            // a byte past the limit kills the frame
            if (byte_count >= lim) begin
              ns = L_BAD;
            end else begin
              dat        = {hi_nib, nib_of(c)};
              byte_count = byte_count + 13'd1;
              kind       = KIND_BYTE;
              emit       = 1'b1;
            end
          end
        end else begin
          // an odd nibble left here is simply dropped
          ns = need_char(c, CH_CR, L_RXD_CR);
        end
      end
      L_RXD_CR: begin
        ns = need_char(c, CH_LF, L_IDLE);
        if (ns == L_IDLE) begin
          kind = KIND_FRAME;
          len  = byte_count;
          emit = 1'b1;
        end
      end
      // $MMTDN,result,pn
      L_T:        ns = need_char(c, CH_D, L_TD);
      L_TD:       ns = need_char(c, CH_N, L_TDN);
      L_TDN:      ns = need_char(c, CH_COMMA, L_TDN_C1);
      L_TDN_C1:   ns = is_dec(c) ? L_TDN_RES : L_BAD;
      L_TDN_RES:  ns = stay_or_sep(is_dec(c), c, CH_COMMA, L_TDN_RES, L_TDN_C2);
      L_TDN_C2:   ns = is_dec(c) ? L_TDN_PN : L_BAD;
      L_TDN_PN:   ns = stay_or_sep(is_dec(c), c, CH_CR, L_TDN_PN, L_TDN_CR);
      L_TDN_CR: begin
        ns = need_char(c, CH_LF, L_IDLE);
        if (ns == L_IDLE) begin
          kind  = KIND_TXDONE;
          emit  = 1'b1;
          tx_st = HS_READY;
        end
      end
      default:    ns = L_BAD;
    endcase

    if (ns == L_BAD) begin
      // bad character is consumed, parser back to idle
      line_st = L_IDLE;
      nib_odd = 1'b0;
      has     = 1'b1;
      r       = '{KIND_PERR, 8'd0, 13'd0, tx_st == HS_READY};
    end else begin
      line_st = ns;
      if (ns == L_IDLE) nib_odd = 1'b0;
      if (emit) begin
        has = 1'b1;
        r   = '{kind, dat, len, tx_st == HS_READY};
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // monitor: model on every feed word taken, check on every report word
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    bit      has;
    result_t pred;
    result_t want;
    if (!rst) begin
      if (feed.valid && feed.ready) begin
        parse_word(feed.mode, feed.rx_byte, has, pred);
        if (typed_hit) pending_reports.push_back(typed_word);
        else if (has) pending_reports.push_back(pred);
      end
      if (report.valid && report.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report word with nothing expected: kind %0d data %0d len %0d",
                 report.kind, report.data, report.payload_len);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          if (report.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, report.kind);
            fails++;
          end
          if (report.data !== want.data) begin
            $error("data: expected %0d, got %0d", want.data, report.data);
            fails++;
          end
          if (report.payload_len !== want.payload_len) begin
            $error("payload_len: expected %0d, got %0d", want.payload_len,
                   report.payload_len);
            fails++;
          end
          if (report.tx_ready !== want.tx_ready) begin
            $error("tx_ready: expected %0d, got %0d", want.tx_ready, report.tx_ready);
            fails++;
          end
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  int stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (feed.valid && feed.ready) || (report.valid && report.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // report side back-pressure
  always @(negedge clk) begin
    report.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // -------------------------------------------------------------------------
  // feed side driver; entered and left on a falling edge
  // -------------------------------------------------------------------------
  task automatic push_word(input logic m, input logic [7:0] c,
                           input bit pinned, input result_t pinned_res);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      feed.valid <= 1'b0;
      @(negedge clk);
    end
    feed.valid   <= 1'b1;
    feed.mode    <= m;
    feed.rx_byte <= c;
    typed_hit  = pinned;
    typed_word = pinned_res;
    do @(posedge clk); while (!feed.ready);
    words_sent++;
    @(negedge clk);
  endtask

  // wait for the parser to go quiet, then write the payload limit
  task automatic apply_limit(input logic [12:0] v);
    feed.valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    // a quiet character may still sit in the pipe
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = v;
  endtask

  // -------------------------------------------------------------------------
  // random line builder
  // -------------------------------------------------------------------------
  function automatic logic [7:0] pick_char(char_cls_e cls);
    logic [7:0] cmd_set [8] = '{CH_H, CH_T, CH_X, CH_D, CH_A, CH_C, CH_W, CH_R};
    int         h;
    case (cls)
      CLS_DIGIT: return CH_ZERO + 8'($urandom_range(0, 9));
      CLS_CMD:   return cmd_set[$urandom_range(0, 7)];
      CLS_HEX: begin
        h = $urandom_range(0, 15);
        return (h < 10) ? CH_ZERO + 8'(h) : CH_A + 8'(h - 10);
      end
      default: begin
        // oky args: digits, letters of either case and commas
        case ($urandom_range(0, 3))
          0:       return CH_ZERO + 8'($urandom_range(0, 9));
          1:       return CH_A + 8'($urandom_range(0, 25));
          2:       return CH_LA + 8'($urandom_range(0, 25));
          default: return CH_COMMA;
        endcase
      end
    endcase
  endfunction

  task automatic add_field(input char_cls_e cls, input int n);
    repeat (n) line_buf.push_back(pick_char(cls));
  endtask

  task automatic make_line();
    int n;
    line_buf = '{CH_DOLLAR, CH_M, CH_M};
    case ($urandom_range(0, 5))
      0: begin
        line_buf.push_back(CH_E);
        line_buf.push_back(CH_R);
        line_buf.push_back(CH_R);
        line_buf.push_back(CH_COMMA);
        add_field(CLS_CMD, $urandom_range(1, 3));
        line_buf.push_back(CH_COMMA);
        add_field(CLS_DIGIT, $urandom_range(1, 3));
      end
      1: begin
        line_buf.push_back(CH_O);
        line_buf.push_back(CH_K);
        line_buf.push_back(CH_Y);
        line_buf.push_back(CH_COMMA);
        add_field(CLS_CMD, $urandom_range(1, 3));
        if ($urandom_range(0, 1)) begin
          line_buf.push_back(CH_COMMA);
          add_field(CLS_ARG, $urandom_range(0, 4));
        end
      end
      2: begin
        line_buf.push_back(CH_T);
        line_buf.push_back(CH_D);
        line_buf.push_back(CH_N);
        line_buf.push_back(CH_COMMA);
        add_field(CLS_DIGIT, $urandom_range(1, 3));
        line_buf.push_back(CH_COMMA);
        add_field(CLS_DIGIT, $urandom_range(1, 3));
      end
      default: begin
        line_buf.push_back(CH_R);
        line_buf.push_back(CH_X);
        line_buf.push_back(CH_D);
        line_buf.push_back(CH_COMMA);
        add_field(CLS_DIGIT, $urandom_range(1, 3));
        line_buf.push_back(CH_COMMA);
        add_field(CLS_DIGIT, $urandom_range(1, 3));
        line_buf.push_back(CH_COMMA);
        // mostly short payloads, now and then a long one; odd counts too
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 80) : $urandom_range(1, 12);
        add_field(CLS_HEX, n);
      end
    endcase
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
  endtask

  // one line, possibly broken, with transmit requests sprinkled in
  task automatic send_random_line();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    make_line();
    if (pick < 10) begin
      // plain noise
      line_buf.delete();
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom));
    end else if (pick < 18) begin
      // one character replaced by a random byte
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom);
    end else if (pick < 25) begin
      // line cut short, the next '$' then lands mid-line
      n = $urandom_range(1, line_buf.size() - 1);
      while (line_buf.size() > n) void'(line_buf.pop_back());
    end
    foreach (line_buf[i]) begin
      if ($urandom_range(0, 99) < 2) push_word(1'b1, 8'($urandom), 1'b0, '0);
      push_word(1'b0, line_buf[i], 1'b0, '0);
    end
    if ($urandom_range(0, 99) < 8) push_word(1'b1, 8'($urandom), 1'b0, '0);
  endtask

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    stim_row_t   row;
    logic [12:0] phase_limit [PHASES];
    int          target;
    feed.valid   = 1'b0;
    feed.mode    = 1'b0;
    feed.rx_byte = 8'd0;
    report.ready = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 13'd0;

    // reset value first, then zero, the smallest, tiny, largest, the
    // all-ones word that gets clamped, two and a random one
    phase_limit = '{MAX_PAYLOAD_RESET, 13'd0, 13'd1, 13'd3, 13'd4096,
                    13'd8191, 13'd2, 13'($urandom_range(1, 4096))};

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_words[i]) begin
      row = directed_words[i];
      for (int k = 0; k < row.n_chars; k++) begin
        push_word(row.mode, row.text[8 * (row.n_chars - 1 - k) +: 8],
                  row.pinned && (k == row.n_chars - 1), row.exp);
      end
    end

    // random phases; each limit change waits for the report side to drain
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) apply_limit(phase_limit[ph]);
      steady = (ph == 4);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_random_line();
    end

    feed.valid <= 1'b0;
    steady = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
